// File: rtl/bba_pkg.sv
package bba_pkg;

    localparam int DEF_LEVELS    = 16;
    localparam int DEF_PAGE_BITS = 12;
    localparam int SIZE_W        = 28;
    localparam int ADDR_W        = 32;

    localparam logic [1:0] FUNC_ALLOC = 2'd0;
    localparam logic [1:0] FUNC_FREE  = 2'd1;
    localparam logic [1:0] FUNC_RESV  = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFREE = 2'd1;
    localparam logic [1:0] ST_BAD    = 2'd2;

    localparam logic REG_BASE = 1'b0;

    typedef enum logic [2:0] {
        PTR_HOLD, PTR_SIZE_INIT, PTR_DOWN, PTR_UP, PTR_FROM_CAND, PTR_FREE_INIT
    } ptr_op_t;

    typedef enum logic [2:0] {
        CAND_HOLD, CAND_ZERO, CAND_RESV, CAND_NEXT, CAND_FROM_PTR
    } cand_op_t;

    typedef enum logic [2:0] {
        SEL_CUR, SEL_CAND, SEL_BUDDY, SEL_PARENT, SEL_CHILD0, SEL_CHILD1
    } sel_t;

    typedef enum logic [1:0] {
        USED_HOLD, USED_ADD, USED_SUB
    } used_op_t;

    typedef struct packed {
        logic       ld_req;
        ptr_op_t    ptr_op;
        cand_op_t   cand_op;
        sel_t       rd_sel;
        logic       wr_en;
        logic       wr_data;
        used_op_t   used_op;
        logic       res_set;
        logic [1:0] res_status;
        logic       res_addr_en;
        logic       out_load;
    } bba_cmd_t;

    typedef struct packed {
        logic       clr_busy;
        logic [1:0] func;
        logic       size_big;
        logic       size_gt_bs;
        logic       lvl_zero;
        logic       lvl_leaf;
        logic       rel_out;
        logic       misaligned;
        logic       mark;
        logic       cand_last;
        logic       out_full;
    } bba_sts_t;

endpackage

// File: rtl/buddy_block_allocator.sv
// Channel | Direction | tdata (low bit up)                          | tuser
// s_      | in        | request_size[27:0], address[59:28]          | func[1:0]
// m_      | out       | block_address[31:0], used[59:32], free[87:60] | status[1:0]
// apb     | in        | base_address at byte address 0              | -
//
// One word at a time. Allocate: sizing steps through the levels, then each
// candidate is read and its ancestors checked, then each level up to the root
// is marked; the scan of one tree level over the mark memory sets the worst
// case. Free: climbs level by level to the marked node, then clears levels
// upward. Reserve: sizing plus one candidate. After reset a clearing pass over
// all 2^LEVELS nodes runs with s_tready low. A finished word waits in the
// output register while m_tready is low; the next request is taken meanwhile.
module buddy_block_allocator #(
    parameter int LEVELS    = bba_pkg::DEF_LEVELS,
    parameter int PAGE_BITS = bba_pkg::DEF_PAGE_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // request_size[27:0], address[59:28]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // block_address[31:0], used[59:32], free[87:60]
    output logic [1:0]  m_tuser,   // status[1:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bba_pkg::*;

    logic [ADDR_W-1:0] base_reg;
    bba_cmd_t          cmd;
    bba_sts_t          sts;
    logic [ADDR_W-1:0] blk_addr;
    logic [SIZE_W-1:0] used_b;
    logic [SIZE_W-1:0] free_b;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BASE) ? base_reg : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_BASE) begin
            base_reg <= pwdata;
        end
    end

    bba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bba_dp #(
        .LEVELS    (LEVELS),
        .PAGE_BITS (PAGE_BITS)
    ) u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .base_address      (base_reg),
        .in_func           (s_tuser),
        .in_size           (s_tdata[27:0]),
        .in_address        (s_tdata[59:28]),
        .m_tready          (m_tready),
        .m_tvalid          (m_tvalid),
        .out_status        (m_tuser),
        .out_block_address (blk_addr),
        .out_used_bytes    (used_b),
        .out_free_bytes    (free_b),
        .cmd               (cmd),
        .sts               (sts)
    );

    assign m_tdata = {free_b, used_b, blk_addr};

endmodule

// File: rtl/bba_ctrl.sv
module bba_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              m_tready,
    input  bba_pkg::bba_sts_t sts,
    output bba_pkg::bba_cmd_t cmd
);
    import bba_pkg::*;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SIZE     = 4'd1;
    localparam logic [3:0] S_CAND_RD  = 4'd2;
    localparam logic [3:0] S_CAND_EV  = 4'd3;
    localparam logic [3:0] S_ANC      = 4'd4;
    localparam logic [3:0] S_ANC_BUD  = 4'd5;
    localparam logic [3:0] S_ANC_PAR  = 4'd6;
    localparam logic [3:0] S_MARK     = 4'd7;
    localparam logic [3:0] S_FREE_CHK = 4'd8;
    localparam logic [3:0] S_FUP_RD   = 4'd9;
    localparam logic [3:0] S_FUP_EV   = 4'd10;
    localparam logic [3:0] S_FCH0     = 4'd11;
    localparam logic [3:0] S_FCH1     = 4'd12;
    localparam logic [3:0] S_FCLR     = 4'd13;
    localparam logic [3:0] S_FCLR_EV  = 4'd14;
    localparam logic [3:0] S_DONE     = 4'd15;

    logic [3:0] state_reg, state_next;
    logic       reject;

    assign s_tready = (state_reg == S_IDLE) && !sts.clr_busy;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        reject     = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    cmd.ld_req = 1'b1;
                    cmd.ptr_op = PTR_SIZE_INIT;
                    state_next = S_FREE_CHK;
                end
            end
            S_FREE_CHK: begin
                priority if (sts.func == FUNC_ALLOC || sts.func == FUNC_RESV) begin
                    state_next = S_SIZE;
                end else if (sts.func == FUNC_FREE) begin
                    if (sts.rel_out) begin
                        cmd.res_set    = 1'b1;
                        cmd.res_status = ST_BAD;
                        state_next     = S_DONE;
                    end else begin
                        cmd.ptr_op = PTR_FREE_INIT;
                        state_next = S_FUP_RD;
                    end
                end else begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_BAD;
                    state_next     = S_DONE;
                end
            end
            S_SIZE: begin
                priority if (sts.size_big) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_BAD;
                    state_next     = S_DONE;
                end else if (!sts.lvl_zero && sts.size_gt_bs) begin
                    cmd.ptr_op = PTR_DOWN;
                end else if (sts.func == FUNC_ALLOC) begin
                    cmd.cand_op = CAND_ZERO;
                    state_next  = S_CAND_RD;
                end else if (sts.rel_out || sts.misaligned) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_BAD;
                    state_next     = S_DONE;
                end else begin
                    cmd.cand_op = CAND_RESV;
                    state_next  = S_CAND_RD;
                end
            end
            S_CAND_RD: begin
                cmd.rd_sel = SEL_CAND;
                cmd.ptr_op = PTR_FROM_CAND;
                state_next = S_CAND_EV;
            end
            S_CAND_EV: begin
                if (sts.mark) begin
                    reject = 1'b1;
                end else begin
                    state_next = S_ANC;
                end
            end
            S_ANC: begin
                if (sts.lvl_zero) begin
                    cmd.ptr_op = PTR_FROM_CAND;
                    state_next = S_MARK;
                end else begin
                    cmd.rd_sel = SEL_BUDDY;
                    state_next = S_ANC_BUD;
                end
            end
            S_ANC_BUD: begin
                if (sts.mark) begin
                    cmd.ptr_op = PTR_FROM_CAND;
                    state_next = S_MARK;
                end else begin
                    cmd.rd_sel = SEL_PARENT;
                    cmd.ptr_op = PTR_UP;
                    state_next = S_ANC_PAR;
                end
            end
            S_ANC_PAR: begin
                if (sts.mark) begin
                    reject = 1'b1;
                end else begin
                    state_next = S_ANC;
                end
            end
            S_MARK: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_data = 1'b1;
                if (sts.lvl_zero) begin
                    cmd.used_op     = USED_ADD;
                    cmd.res_set     = 1'b1;
                    cmd.res_status  = ST_OK;
                    cmd.res_addr_en = 1'b1;
                    state_next      = S_DONE;
                end else begin
                    cmd.ptr_op = PTR_UP;
                end
            end
            S_FUP_RD: begin
                cmd.rd_sel = SEL_CUR;
                state_next = S_FUP_EV;
            end
            S_FUP_EV: begin
                priority if (sts.mark) begin
                    cmd.cand_op = CAND_FROM_PTR;
                    if (sts.lvl_leaf) begin
                        state_next = S_FCLR;
                    end else begin
                        cmd.rd_sel = SEL_CHILD0;
                        state_next = S_FCH0;
                    end
                end else if (sts.lvl_zero) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_BAD;
                    state_next     = S_DONE;
                end else begin
                    cmd.ptr_op = PTR_UP;
                    state_next = S_FUP_RD;
                end
            end
            S_FCH0: begin
                if (sts.mark) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_BAD;
                    state_next     = S_DONE;
                end else begin
                    cmd.rd_sel = SEL_CHILD1;
                    state_next = S_FCH1;
                end
            end
            S_FCH1: begin
                if (sts.mark) begin
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_BAD;
                    state_next     = S_DONE;
                end else begin
                    state_next = S_FCLR;
                end
            end
            S_FCLR: begin
                cmd.wr_en   = 1'b1;
                cmd.wr_data = 1'b0;
                if (sts.lvl_zero) begin
                    cmd.used_op    = USED_SUB;
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_OK;
                    state_next     = S_DONE;
                end else begin
                    cmd.rd_sel = SEL_BUDDY;
                    state_next = S_FCLR_EV;
                end
            end
            S_FCLR_EV: begin
                if (sts.mark) begin
                    cmd.used_op    = USED_SUB;
                    cmd.res_set    = 1'b1;
                    cmd.res_status = ST_OK;
                    state_next     = S_DONE;
                end else begin
                    cmd.ptr_op = PTR_UP;
                    state_next = S_FCLR;
                end
            end
            S_DONE: begin
                if (!sts.out_full || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        if (reject) begin
            if (sts.func == FUNC_ALLOC && !sts.cand_last) begin
                cmd.cand_op = CAND_NEXT;
                state_next  = S_CAND_RD;
            end else begin
                cmd.res_set    = 1'b1;
                cmd.res_status = ST_NOFREE;
                state_next     = S_DONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/bba_dp.sv
module bba_dp #(
    parameter int LEVELS    = bba_pkg::DEF_LEVELS,
    parameter int PAGE_BITS = bba_pkg::DEF_PAGE_BITS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [bba_pkg::ADDR_W-1:0]  base_address,
    input  logic [1:0]                  in_func,
    input  logic [bba_pkg::SIZE_W-1:0]  in_size,
    input  logic [bba_pkg::ADDR_W-1:0]  in_address,
    input  logic                        m_tready,
    output logic                        m_tvalid,
    output logic [1:0]                  out_status,
    output logic [bba_pkg::ADDR_W-1:0]  out_block_address,
    output logic [bba_pkg::SIZE_W-1:0]  out_used_bytes,
    output logic [bba_pkg::SIZE_W-1:0]  out_free_bytes,
    input  bba_pkg::bba_cmd_t           cmd,
    output bba_pkg::bba_sts_t           sts
);
    import bba_pkg::*;

    localparam int RB    = LEVELS - 1 + PAGE_BITS;
    localparam int NODES = 1 << LEVELS;
    localparam int LW    = $clog2(LEVELS);
    localparam int OW    = LEVELS - 1;
    localparam int UW    = RB + 1;
    localparam int CW    = (RB + 1 > SIZE_W) ? RB + 1 : SIZE_W;

    function automatic logic [LEVELS-1:0] node_idx(input logic [LW-1:0] l,
                                                   input logic [OW-1:0] o);
        logic [LEVELS:0] t;
        t = ((LEVELS+1)'(1) << l) - (LEVELS+1)'(1) + (LEVELS+1)'(o);
        return t[LEVELS-1:0];
    endfunction

    logic [1:0]        func_reg;
    logic [SIZE_W-1:0] size_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [LW-1:0]     lvl_reg, lvl_next;
    logic [OW-1:0]     off_reg, off_next;
    logic [LW-1:0]     cand_lvl_reg, cand_lvl_next;
    logic [OW-1:0]     cand_off_reg, cand_off_next;
    logic [UW-1:0]     used_reg, used_next;
    logic [1:0]        res_status_reg;
    logic [ADDR_W-1:0] res_addr_reg;
    logic              m_valid_reg;
    logic [1:0]        m_status_reg;
    logic [ADDR_W-1:0] m_addr_reg;
    logic [SIZE_W-1:0] m_used_reg;
    logic [SIZE_W-1:0] m_free_reg;
    logic [LEVELS:0]   clr_cnt_reg;
    logic              clr_busy;

    logic              mem [NODES];
    logic              mark_q;
    logic [LEVELS-1:0] rd_idx;
    logic [LEVELS-1:0] wr_idx;
    logic              wr_en;
    logic              wr_data;

    logic [ADDR_W-1:0] rel;
    logic [63:0]       rel64;
    logic [CW-1:0]     size_eff;
    logic [CW-1:0]     bs_cur;
    logic [63:0]       bs_cur64;
    logic [UW-1:0]     bs_cand;
    logic [OW:0]       cand_n;
    logic [63:0]       blk_off;
    logic [63:0]       blk_sum;
    logic [UW-1:0]     free_w;

    assign clr_busy = !clr_cnt_reg[LEVELS];
    assign rel      = addr_reg - base_address;
    assign rel64    = 64'(rel);
    assign size_eff = (CW'(size_reg) < (CW'(1) << PAGE_BITS)) ? (CW'(1) << PAGE_BITS)
                                                               : CW'(size_reg);
    assign bs_cur   = CW'(1) << (RB - int'(lvl_reg));
    assign bs_cur64 = 64'(1) << (RB - int'(lvl_reg));
    assign bs_cand  = UW'(1) << (RB - int'(cand_lvl_reg));
    assign cand_n   = (OW+1)'(1) << cand_lvl_reg;
    assign blk_off  = 64'(cand_off_reg) << (RB - int'(cand_lvl_reg));
    assign blk_sum  = 64'(base_address) + blk_off;
    assign free_w   = (UW'(1) << RB) - used_reg;

    always_comb begin
        sts            = '0;
        sts.clr_busy   = clr_busy;
        sts.func       = func_reg;
        sts.size_big   = size_eff > (CW'(1) << RB);
        sts.size_gt_bs = size_eff > bs_cur;
        sts.lvl_zero   = (lvl_reg == '0);
        sts.lvl_leaf   = (lvl_reg == LW'(LEVELS - 1));
        sts.rel_out    = rel64 >= (64'(1) << RB);
        sts.misaligned = (rel64 & (bs_cur64 - 64'(1))) != 64'(0);
        sts.mark       = mark_q;
        sts.cand_last  = (OW+1)'(cand_off_reg) == (cand_n - (OW+1)'(1));
        sts.out_full   = m_valid_reg;
    end

    always_comb begin
        unique case (cmd.rd_sel)
            SEL_CUR:    rd_idx = node_idx(lvl_reg, off_reg);
            SEL_CAND:   rd_idx = node_idx(cand_lvl_reg, cand_off_reg);
            SEL_BUDDY:  rd_idx = node_idx(lvl_reg, off_reg ^ OW'(1));
            SEL_PARENT: rd_idx = node_idx(lvl_reg - LW'(1), off_reg >> 1);
            SEL_CHILD0: rd_idx = node_idx(lvl_reg + LW'(1), off_reg << 1);
            SEL_CHILD1: rd_idx = node_idx(lvl_reg + LW'(1), (off_reg << 1) | OW'(1));
            default:    rd_idx = node_idx(lvl_reg, off_reg);
        endcase
    end

    always_comb begin
        if (clr_busy) begin
            wr_en   = 1'b1;
            wr_idx  = clr_cnt_reg[LEVELS-1:0];
            wr_data = 1'b0;
        end else begin
            wr_en   = cmd.wr_en;
            wr_idx  = node_idx(lvl_reg, off_reg);
            wr_data = cmd.wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
        mark_q <= mem[rd_idx];
    end

    always_comb begin
        lvl_next = lvl_reg;
        off_next = off_reg;
        unique case (cmd.ptr_op)
            PTR_HOLD: ;
            PTR_SIZE_INIT: lvl_next = LW'(LEVELS - 1);
            PTR_DOWN:      lvl_next = lvl_reg - LW'(1);
            PTR_UP: begin
                lvl_next = lvl_reg - LW'(1);
                off_next = off_reg >> 1;
            end
            PTR_FROM_CAND: begin
                lvl_next = cand_lvl_reg;
                off_next = cand_off_reg;
            end
            PTR_FREE_INIT: begin
                lvl_next = LW'(LEVELS - 1);
                off_next = OW'(rel64 >> PAGE_BITS);
            end
            default: ;
        endcase
    end

    always_comb begin
        cand_lvl_next = cand_lvl_reg;
        cand_off_next = cand_off_reg;
        unique case (cmd.cand_op)
            CAND_HOLD: ;
            CAND_ZERO: begin
                cand_lvl_next = lvl_reg;
                cand_off_next = '0;
            end
            CAND_RESV: begin
                cand_lvl_next = lvl_reg;
                cand_off_next = OW'(rel64 >> (RB - int'(lvl_reg)));
            end
            CAND_NEXT: cand_off_next = cand_off_reg + OW'(1);
            CAND_FROM_PTR: begin
                cand_lvl_next = lvl_reg;
                cand_off_next = off_reg;
            end
            default: ;
        endcase
    end

    always_comb begin
        unique case (cmd.used_op)
            USED_HOLD: used_next = used_reg;
            USED_ADD:  used_next = used_reg + bs_cand;
            USED_SUB:  used_next = (used_reg >= bs_cand) ? used_reg - bs_cand : '0;
            default:   used_next = used_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_req) begin
            func_reg <= in_func;
            size_reg <= in_size;
            addr_reg <= in_address;
        end
        lvl_reg      <= lvl_next;
        off_reg      <= off_next;
        cand_lvl_reg <= cand_lvl_next;
        cand_off_reg <= cand_off_next;
        if (cmd.res_set) begin
            res_status_reg <= cmd.res_status;
            res_addr_reg   <= cmd.res_addr_en ? blk_sum[ADDR_W-1:0] : '0;
        end
        if (cmd.out_load) begin
            m_status_reg <= res_status_reg;
            m_addr_reg   <= res_addr_reg;
            m_used_reg   <= SIZE_W'(used_reg);
            m_free_reg   <= SIZE_W'(free_w);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
            clr_cnt_reg <= '0;
        end else begin
            used_reg <= used_next;
            if (clr_busy) begin
                clr_cnt_reg <= clr_cnt_reg + (LEVELS+1)'(1);
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid          = m_valid_reg;
    assign out_status        = m_status_reg;
    assign out_block_address = m_addr_reg;
    assign out_used_bytes    = m_used_reg;
    assign out_free_bytes    = m_free_reg;

    a_used_in_region: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= (UW'(1) << RB))
        else $error("used byte count beyond region");

    a_no_req_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy |-> !cmd.ld_req)
        else $error("request taken during clearing pass");

    a_out_free_on_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_tready))
        else $error("output word overwritten");

    a_tree_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.wr_en || cmd.used_op != USED_HOLD) |-> !clr_busy)
        else $error("tree update during clearing pass");

endmodule

// File: tb/sv/bba_checker.sv
module bba_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [87:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending
);
    import bba_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     LV         = DEF_LEVELS;
    localparam int     PB         = DEF_PAGE_BITS;
    localparam int     RBITS      = LV - 1 + PB;
    localparam longint REGION     = 64'd1 << RBITS;
    localparam int     NODES      = 1 << LV;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] block_addr;
        logic [SIZE_W-1:0] used;
        logic [SIZE_W-1:0] free;
    } alloc_result_t;

    logic              tree_mark [NODES];
    longint            used_total;
    logic [ADDR_W-1:0] region_base;
    alloc_result_t     expected_results [$];

    function automatic int node_idx(int l, int o);
        return ((1 << l) - 1 + o) & (NODES - 1);
    endfunction

    function automatic bit is_marked(int l, int o);
        return tree_mark[node_idx(l, o)];
    endfunction

    function automatic bit level_of_size(longint sz, output int l);
        longint q;
        l = 0;
        if (sz < (64'd1 << PB)) sz = 64'd1 << PB;
        if (sz > REGION) return 0;
        q = REGION / sz;
        while (q > 1) begin
            q = q >> 1;
            l++;
        end
        if (l > LV - 1) l = LV - 1;
        return 1;
    endfunction

    function automatic bit path_clear(int l, int o);
        while (l > 0 && !is_marked(l, o ^ 1)) begin
            o = o >> 1;
            l--;
            if (is_marked(l, o)) return 0;
        end
        return 1;
    endfunction

    function automatic void mark_up(int l, int o);
        forever begin
            tree_mark[node_idx(l, o)] = 1'b1;
            if (l == 0) break;
            o = o >> 1;
            l--;
        end
    endfunction

    function automatic void clear_up(int l, int o);
        tree_mark[node_idx(l, o)] = 1'b0;
        while (l > 0 && !is_marked(l, o ^ 1)) begin
            o = o >> 1;
            l--;
            tree_mark[node_idx(l, o)] = 1'b0;
        end
    endfunction

    function automatic alloc_result_t predict_alloc(logic [1:0] fn, logic [SIZE_W-1:0] sz,
                                                    logic [ADDR_W-1:0] addr);
        alloc_result_t     r;
        logic [ADDR_W-1:0] rel;
        longint            bs;
        int                l;
        int                o;
        bit                found;
        rel = addr - region_base;
        r.status = ST_BAD;
        r.block_addr = '0;
        l = 0;
        if (fn == FUNC_ALLOC) begin
            if (level_of_size(longint'(sz), l)) begin
                r.status = ST_NOFREE;
                for (o = 0; o < (1 << l); o++) begin
                    if (!is_marked(l, o) && path_clear(l, o)) begin
                        bs = REGION >> l;
                        mark_up(l, o);
                        used_total += bs;
                        r.block_addr = region_base + ADDR_W'(bs * o);
                        r.status = ST_OK;
                        break;
                    end
                end
            end
        end else if (fn == FUNC_FREE) begin
            if (longint'(rel) < REGION) begin
                found = 0;
                o = int'(rel >> PB);
                l = LV - 1;
                forever begin
                    if (is_marked(l, o)) begin
                        found = 1;
                        break;
                    end
                    if (l == 0) break;
                    o = o >> 1;
                    l--;
                end
                if (found && (l == LV - 1 ||
                              (!is_marked(l + 1, o << 1) && !is_marked(l + 1, (o << 1) | 1))))
                begin
                    bs = REGION >> l;
                    clear_up(l, o);
                    used_total = (used_total >= bs) ? used_total - bs : 0;
                    r.status = ST_OK;
                end
            end
        end else if (fn == FUNC_RESV) begin
            if (level_of_size(longint'(sz), l) && longint'(rel) < REGION) begin
                bs = REGION >> l;
                if ((longint'(rel) & (bs - 1)) == 0) begin
                    o = int'(longint'(rel) / bs);
                    if (!is_marked(l, o) && path_clear(l, o)) begin
                        mark_up(l, o);
                        used_total += bs;
                        r.block_addr = region_base + ADDR_W'(bs * o);
                        r.status = ST_OK;
                    end else begin
                        r.status = ST_NOFREE;
                    end
                end
            end
        end
        r.used = SIZE_W'(used_total);
        r.free = SIZE_W'(REGION - ((used_total <= REGION) ? used_total : REGION));
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("ERROR %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
        fail_count++;
    endtask

    assign pending = expected_results.size();

    always @(posedge aclk) begin
        alloc_result_t e;
        if (!aresetn) begin
            foreach (tree_mark[i]) tree_mark[i] = 1'b0;
            used_total = 0;
            region_base = '0;
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected word", m_tdata[31:0], 0);
                end else begin
                    e = expected_results.pop_front();
                    if (m_tuser != e.status)
                        report_mismatch("status", m_tuser, e.status);
                    if (m_tdata[31:0] != e.block_addr)
                        report_mismatch("block_address", m_tdata[31:0], e.block_addr);
                    if (m_tdata[59:32] != e.used)
                        report_mismatch("used_bytes", m_tdata[59:32], e.used);
                    if (m_tdata[87:60] != e.free)
                        report_mismatch("free_bytes", m_tdata[87:60], e.free);
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(predict_alloc(s_tuser, s_tdata[27:0],
                                                         s_tdata[59:28]));
            if (psel && penable && pwrite && pready && paddr == 3'(4 * REG_BASE))
                region_base = pwdata;
        end
    end
endmodule

// File: tb/sv/tb_buddy_block_allocator.sv
module tb_buddy_block_allocator;
    import bba_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int      RBITS = DEF_LEVELS - 1 + DEF_PAGE_BITS;
    localparam longint  LIMIT = 400_000_000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;

    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    int          rx_hold = 0;
    logic        hold_arm = 1'b0;
    logic        hold_used = 1'b0;
    logic [31:0] base_now = '0;
    longint      cycles = 0;

    always #5 aclk = ~aclk;

    buddy_block_allocator dut (.*);

    bba_checker chk (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("buddy_block_allocator: mismatch");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_tready <= 1'b0;
        end else if (hold_arm && !hold_used) begin
            hold_used <= 1'b1;
            rx_hold <= 400;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic apb_write(logic [31:0] v);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(4 * REG_BASE);
        pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        base_now = v;
    endtask

    task automatic send_request(logic [1:0] fn, logic [27:0] sz, logic [31:0] addr);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= fn;
        s_tdata <= {4'b0, addr, sz};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (20) @(posedge aclk);
    endtask

    function automatic int pick_level();
        int r;
        r = $urandom_range(0, 99);
        if (r < 2) return 15;
        if (r < 10) return $urandom_range(9, 14);
        return $urandom_range(0, 8);
    endfunction

    function automatic logic [27:0] size_for(int l);
        longint bs;
        bs = 64'd1 << (RBITS - l);
        if (l == 15) return 28'($urandom_range(0, 4096));
        return 28'($urandom_range(int'(bs / 2 + 1), int'(bs)));
    endfunction

    task automatic random_request;
        int          r;
        int          l;
        logic [31:0] rel;
        r = $urandom_range(0, 99);
        l = pick_level();
        if (r < 42) begin
            send_request(FUNC_ALLOC, size_for(l), $urandom);
        end else if (r < 77) begin
            rel = $urandom_range(0, (1 << RBITS) - 1);
            send_request(FUNC_FREE, 28'($urandom), base_now + rel);
        end else if (r < 90) begin
            rel = 32'($urandom_range(0, (1 << l) - 1)) << (RBITS - l);
            send_request(FUNC_RESV, size_for(l), base_now + rel);
        end else begin
            send_request(2'($urandom_range(0, 3)), 28'($urandom), $urandom);
        end
    endtask

    initial begin
        logic [31:0] bases [3];
        bases[0] = 32'h0000_0000;
        bases[1] = 32'hFFFF_FFFF;
        bases[2] = $urandom;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_pct = 21;
        rx_idle_pct = 79;
        send_request(FUNC_ALLOC, 28'h800_0000, 32'h0);
        send_request(FUNC_ALLOC, 28'h0, 32'h0);
        send_request(FUNC_FREE, 28'h0, 32'h0);
        send_request(FUNC_ALLOC, 28'h0, 32'hFFFF_FFFF);
        send_request(FUNC_ALLOC, 28'd4097, 32'h0);
        send_request(FUNC_FREE, 28'h0, 32'h1000);
        send_request(FUNC_ALLOC, 28'h800_0001, 32'h0);
        send_request(FUNC_ALLOC, 28'hFFF_FFFF, 32'h0);
        send_request(FUNC_RESV, 28'd8192, 32'h1000);
        send_request(FUNC_RESV, 28'h0, 32'h0);
        send_request(FUNC_RESV, 28'd4096, 32'h2000);
        send_request(FUNC_RESV, 28'h400_0000, 32'h400_0000);
        send_request(FUNC_RESV, 28'h400_0000, 32'h800_0000);
        send_request(FUNC_FREE, 28'h0, 32'hFFFF_FFFF);
        send_request(FUNC_FREE, 28'h0, 32'h200_0000);
        send_request(FUNC_FREE, 28'hFFF_FFFF, 32'h7FF_FFFF);
        send_request(FUNC_FREE, 28'h0, 32'h7FF_FFFF);
        send_request(2'd3, 28'hFFF_FFFF, 32'hFFFF_FFFF);
        send_request(FUNC_FREE, 28'h0, 32'h2FFF);
        send_request(FUNC_FREE, 28'h0, 32'h0);
        send_request(FUNC_ALLOC, 28'd1, 32'h0);
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            apb_write(bases[ph]);
            tx_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 79 : 0;
            rx_idle_pct = (ph == 0) ? 79 : (ph == 1) ? 21 : 0;
            for (int i = 0; i < 260; i++) begin
                if (ph == 2 && i == 40) hold_arm <= 1'b1;
                random_request();
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("buddy_block_allocator: match");
        end else begin
            $display("buddy_block_allocator: mismatch");
        end
        $finish;
    end
endmodule
